// File: hdl/fblr_pkg.sv
// Shared constants for the framebuffer line rasterizer.
`default_nettype none

package fblr_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int ROWS_PER_PAGE  = 8;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
    localparam int STORE_DEPTH    = 1024;
    localparam int ADDR_W         = 10;
    localparam int USED_BYTES     = DISPLAY_WIDTH * PAGE_COUNT;

    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

endpackage

`default_nettype wire

// File: hdl/framebuffer_line_rasterizer_core.sv
// Page-layout monochrome framebuffer with a sequential Bresenham line walker.
//
//  channel  | dir | fields in tdata, lowest bit first
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | op[1:0] start_x[9:2] start_y[17:10] end_x[25:18]
//           |     | end_y[33:26] read_index[43:34], zero fill [47:44]
//  m_axis   | out | read_data[7:0]
//
// One item at a time; s_tready is high only while the sequencer is idle.
// Line: orient, order, a read and write back per pixel on the panel, a bare walk step per
// skipped pixel, finish. Read: read, finish. Clear: zero all 1024 bytes, one byte a cycle.
// After reset the store is swept to zero, all 1024 bytes, before s_tready rises.
// A result waits in the output register; the walker holds in its last state
// until that register is free.
`default_nettype none

module framebuffer_line_rasterizer_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [47:0] s_tdata,   // op, start_x, start_y, end_x, end_y, read_index
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata    // read_data
);

    localparam logic [2:0] ST_WIPE   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ORIENT = 3'd2;
    localparam logic [2:0] ST_ORDER  = 3'd3;
    localparam logic [2:0] ST_PIX    = 3'd4;
    localparam logic [2:0] ST_PIX_WR = 3'd5;
    localparam logic [2:0] ST_READ   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    localparam int AW = fblr_pkg::ADDR_W;

    // control
    logic [2:0]    state_reg, state_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0] wipe_cnt_reg, wipe_cnt_next;
    logic          wipe_op_reg, wipe_op_next;

    // payload
    logic [1:0]    op_reg, op_next;
    logic [7:0]    sx_reg, sx_next, sy_reg, sy_next, ex_reg, ex_next, ey_reg, ey_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic          hit_reg, hit_next;
    logic [7:0]    ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    logic          steep_reg, steep_next, up_reg, up_next;
    logic [7:0]    run_reg, run_next, rise_reg, rise_next;
    logic signed [9:0] err_reg, err_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    mask_reg, mask_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;

    // store
    logic [7:0]    frame_mem [fblr_pkg::STORE_DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata_reg;

    // walker datapath
    logic [7:0]    adx, ady, o_ax, o_ay, o_bx, o_by, o_run;
    logic          o_swap;
    logic [7:0]    pix_col, pix_row;
    logic [10:0]   pix_idx;
    logic          pix_on;
    logic signed [9:0] err_sub;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        adx    = (ex_reg >= sx_reg) ? (ex_reg - sx_reg) : (sx_reg - ex_reg);
        ady    = (ey_reg >= sy_reg) ? (ey_reg - sy_reg) : (sy_reg - ey_reg);
        o_swap = (ax_reg > bx_reg);
        o_ax   = o_swap ? bx_reg : ax_reg;
        o_ay   = o_swap ? by_reg : ay_reg;
        o_bx   = o_swap ? ax_reg : bx_reg;
        o_by   = o_swap ? ay_reg : by_reg;
        o_run  = o_bx - o_ax;

        pix_col = steep_reg ? ay_reg : ax_reg;
        pix_row = steep_reg ? ax_reg : ay_reg;
        pix_idx = 11'(pix_col) + 11'(pix_row[7:3]) * 11'(fblr_pkg::DISPLAY_WIDTH);
        pix_on  = (9'(pix_col) < 9'(fblr_pkg::DISPLAY_WIDTH))
               && (9'(pix_row) < 9'(fblr_pkg::DISPLAY_HEIGHT))
               && (12'(pix_idx) < 12'(fblr_pkg::STORE_DEPTH));
        err_sub = err_reg - $signed({2'b00, rise_reg});
    end

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wipe_cnt_next = wipe_cnt_reg;
        wipe_op_next  = wipe_op_reg;
        op_next       = op_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        ridx_next     = ridx_reg;
        hit_next      = hit_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        steep_next    = steep_reg;
        up_next       = up_reg;
        run_next      = run_reg;
        rise_next     = rise_reg;
        err_next      = err_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = idx_reg;
        mem_raddr     = AW'(pix_idx);
        mem_wdata     = mem_rdata_reg | mask_reg;

        unique case (state_reg)
            ST_WIPE:
            begin
                mem_we        = 1'b1;
                mem_waddr     = wipe_cnt_reg;
                mem_wdata     = 8'h00;
                wipe_cnt_next = wipe_cnt_reg + AW'(1);
                if (&wipe_cnt_reg)
                begin
                    state_next = wipe_op_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next   = s_tdata[1:0];
                    sx_next   = s_tdata[9:2];
                    sy_next   = s_tdata[17:10];
                    ex_next   = s_tdata[25:18];
                    ey_next   = s_tdata[33:26];
                    ridx_next = s_tdata[43:34];
                    unique case (s_tdata[1:0])
                        fblr_pkg::OP_LINE:  state_next = ST_ORIENT;
                        fblr_pkg::OP_READ:  state_next = ST_READ;
                        fblr_pkg::OP_CLEAR:
                        begin
                            wipe_op_next = 1'b1;
                            state_next   = ST_WIPE;
                        end
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ORIENT:
            begin
                // walk along the larger axis
                steep_next = (ady > adx);
                ax_next    = (ady > adx) ? sy_reg : sx_reg;
                ay_next    = (ady > adx) ? sx_reg : sy_reg;
                bx_next    = (ady > adx) ? ey_reg : ex_reg;
                by_next    = (ady > adx) ? ex_reg : ey_reg;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                ax_next    = o_ax;
                ay_next    = o_ay;
                bx_next    = o_bx;
                by_next    = o_by;
                run_next   = o_run;
                rise_next  = (o_by >= o_ay) ? (o_by - o_ay) : (o_ay - o_by);
                err_next   = $signed({2'b00, o_run >> 1});
                up_next    = (o_ay < o_by);
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                if (ax_reg >= bx_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // fetch the byte for this pixel, then advance the walk
                    mem_re    = pix_on;
                    idx_next  = AW'(pix_idx);
                    mask_next = 8'd1 << pix_row[2:0];
                    if (err_sub < 0)
                    begin
                        ay_next  = up_reg ? (ay_reg + 8'd1) : (ay_reg - 8'd1);
                        err_next = err_sub + $signed({2'b00, run_reg});
                    end
                    else
                    begin
                        err_next = err_sub;
                    end
                    ax_next = ax_reg + 8'd1;
                    if (pix_on)
                    begin
                        state_next = ST_PIX_WR;
                    end
                end
            end
            ST_PIX_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_PIX;
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ridx_reg;
                hit_next   = (12'(ridx_reg) < 12'(fblr_pkg::USED_BYTES));
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (op_reg == fblr_pkg::OP_READ && hit_reg)
                                  ? mem_rdata_reg : 8'h00;
                    wipe_op_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_WIPE;
            m_tvalid_reg <= 1'b0;
            wipe_cnt_reg <= '0;
            wipe_op_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            wipe_cnt_reg <= wipe_cnt_next;
            wipe_op_reg  <= wipe_op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        ridx_reg    <= ridx_next;
        hit_reg     <= hit_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        bx_reg      <= bx_next;
        by_reg      <= by_next;
        steep_reg   <= steep_next;
        up_reg      <= up_next;
        run_reg     <= run_next;
        rise_reg    <= rise_next;
        err_reg     <= err_next;
        idx_reg     <= idx_next;
        mask_reg    <= mask_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= frame_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire
